### sv/cob_pkg.sv
// Shared types, widths and constants of the camera orthonormal basis block.
package cob_pkg;

  // Fixed point widths.
  localparam int unsigned FIX_W      = 32;
  localparam int unsigned MAG_W      = 63;
  localparam int unsigned NM_W       = 30;
  localparam int unsigned SQ_W       = 2 * NM_W;
  localparam int unsigned SUM_W      = 63;
  localparam int unsigned ROOT_W     = 31;
  localparam int unsigned NUM_W      = 61;
  localparam int unsigned QUO_W      = 31;
  localparam int unsigned LEAD_W     = 6;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned Q30_SHIFT  = 30;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 31;

  localparam int unsigned NORM_LAT   = 4 + (SQRT_STEPS + 1) + (DIV_STEPS + 1) + 1;
  localparam int unsigned CROSS_LAT  = 2;
  localparam int unsigned LATENCY    = 1 + 2 * NORM_LAT + 2 * CROSS_LAT + 1;

  localparam logic [LEAD_W-1:0] NORM_LEAD = 6'd29;

  localparam logic signed [FIX_W-1:0] ONE_Q30   = 32'sh4000_0000;
  localparam logic signed [FIX_W-1:0] UP_X_RST  = 32'sd0;
  localparam logic signed [FIX_W-1:0] UP_Y_RST  = 32'sd65536;
  localparam logic signed [FIX_W-1:0] UP_Z_RST  = 32'sd0;
  localparam logic [PROD_W-1:0]       RND_HALF  = 64'h2000_0000;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_UP_X = 2'd0;
  localparam logic [1:0] REG_UP_Y = 2'd1;
  localparam logic [1:0] REG_UP_Z = 2'd2;

  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_DOWN,
    KIND_UP,
    KIND_DEGEN
  } kind_t;

  typedef logic [2:0][FIX_W-1:0]  vec3_t;
  typedef logic [2:0][PROD_W-1:0] wide3_t;

  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } nvec_t;

  typedef struct packed {
    kind_t kind;
    vec3_t w;
    vec3_t u;
  } side_t;

  typedef struct packed {
    logic signed [FIX_W-1:0] pos_x;
    logic signed [FIX_W-1:0] pos_y;
    logic signed [FIX_W-1:0] pos_z;
    logic signed [FIX_W-1:0] tgt_x;
    logic signed [FIX_W-1:0] tgt_y;
    logic signed [FIX_W-1:0] tgt_z;
  } in_t;

  typedef struct packed {
    logic signed [FIX_W-1:0] u_x;
    logic signed [FIX_W-1:0] u_y;
    logic signed [FIX_W-1:0] u_z;
    logic signed [FIX_W-1:0] v_x;
    logic signed [FIX_W-1:0] v_y;
    logic signed [FIX_W-1:0] v_z;
    logic signed [FIX_W-1:0] w_x;
    logic signed [FIX_W-1:0] w_y;
    logic signed [FIX_W-1:0] w_z;
    logic                    degenerate;
  } out_t;

endpackage

### sv/cob_cross.sv
// Two-stage pipelined signed cross product of two Q-format vectors.
module cob_cross (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  cob_pkg::vec3_t    in_a,
  input  cob_pkg::vec3_t    in_b,
  input  cob_pkg::side_t    in_side,
  output logic              out_valid,
  output cob_pkg::wide3_t   out_c,
  output cob_pkg::side_t    out_side
);

  logic                                   p_valid_r;
  logic signed [cob_pkg::PROD_W-1:0]      prod_r [6];
  cob_pkg::side_t                         p_side_r;
  logic                                   c_valid_r;
  cob_pkg::wide3_t                        c_r;
  cob_pkg::side_t                         c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      p_valid_r <= in_valid;
      c_valid_r <= p_valid_r;
    end
  end

  // Products first, differences in the next stage.
  always_ff @(posedge clk) begin
    prod_r[0] <= $signed(in_a[1]) * $signed(in_b[2]);
    prod_r[1] <= $signed(in_a[2]) * $signed(in_b[1]);
    prod_r[2] <= $signed(in_a[2]) * $signed(in_b[0]);
    prod_r[3] <= $signed(in_a[0]) * $signed(in_b[2]);
    prod_r[4] <= $signed(in_a[0]) * $signed(in_b[1]);
    prod_r[5] <= $signed(in_a[1]) * $signed(in_b[0]);
    p_side_r  <= in_side;
    c_r[0]    <= prod_r[0] - prod_r[1];
    c_r[1]    <= prod_r[2] - prod_r[3];
    c_r[2]    <= prod_r[4] - prod_r[5];
    c_side_r  <= p_side_r;
  end

  assign out_valid = c_valid_r;
  assign out_c     = c_r;
  assign out_side  = c_side_r;

endmodule

### sv/cob_norm.sv
// Pipelined vector normalizer: range shift, sum of squares, square root and division.
module cob_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  cob_pkg::nvec_t  in_vec,
  input  cob_pkg::side_t  in_side,
  output logic            out_valid,
  output cob_pkg::vec3_t  out_vec,
  output logic            out_zero,
  output cob_pkg::side_t  out_side
);

  localparam int unsigned MAG_W  = cob_pkg::MAG_W;
  localparam int unsigned NM_W   = cob_pkg::NM_W;
  localparam int unsigned SQ_W   = cob_pkg::SQ_W;
  localparam int unsigned SUM_W  = cob_pkg::SUM_W;
  localparam int unsigned ROOT_W = cob_pkg::ROOT_W;
  localparam int unsigned NUM_W  = cob_pkg::NUM_W;
  localparam int unsigned QUO_W  = cob_pkg::QUO_W;
  localparam int unsigned LEAD_W = cob_pkg::LEAD_W;
  localparam int unsigned FIX_W  = cob_pkg::FIX_W;
  localparam int unsigned RS     = cob_pkg::SQRT_STEPS;
  localparam int unsigned DS     = cob_pkg::DIV_STEPS;

  // Stage A: largest magnitude.
  logic                   a_valid_r;
  cob_pkg::nvec_t         a_vec_r;
  cob_pkg::side_t         a_side_r;
  logic [MAG_W-1:0]       a_max_r;
  logic [MAG_W-1:0]       max_nxt;

  always_comb begin
    max_nxt = in_vec.mag[0];
    if (in_vec.mag[1] > max_nxt) max_nxt = in_vec.mag[1];
    if (in_vec.mag[2] > max_nxt) max_nxt = in_vec.mag[2];
  end

  // Stage B: leading one position of the largest magnitude.
  logic                   b_valid_r;
  cob_pkg::nvec_t         b_vec_r;
  cob_pkg::side_t         b_side_r;
  logic [LEAD_W-1:0]      b_lead_r;
  logic                   b_zero_r;
  logic [LEAD_W-1:0]      lead_nxt;

  always_comb begin
    lead_nxt = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (a_max_r[i]) lead_nxt = LEAD_W'(i);
    end
  end

  // Stage C: shift so that the largest magnitude lies in [2^29, 2^30).
  logic                        c_valid_r;
  logic [2:0][NM_W-1:0]        c_m_r;
  logic [2:0]                  c_neg_r;
  cob_pkg::side_t              c_side_r;
  logic                        c_zero_r;
  logic [2:0][NM_W-1:0]        m_nxt;

  always_comb begin
    logic [MAG_W-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      if (b_lead_r >= cob_pkg::NORM_LEAD) begin
        sh = b_vec_r.mag[i] >> (b_lead_r - cob_pkg::NORM_LEAD);
      end else begin
        sh = b_vec_r.mag[i] << (cob_pkg::NORM_LEAD - b_lead_r);
      end
      m_nxt[i] = sh[NM_W-1:0];
    end
  end

  // Stage D: squares.
  logic                        d_valid_r;
  logic [2:0][SQ_W-1:0]        d_sq_r;
  logic [2:0][NM_W-1:0]        d_m_r;
  logic [2:0]                  d_neg_r;
  cob_pkg::side_t              d_side_r;
  logic                        d_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_vec_r  <= in_vec;
    a_side_r <= in_side;
    a_max_r  <= max_nxt;
    b_vec_r  <= a_vec_r;
    b_side_r <= a_side_r;
    b_lead_r <= lead_nxt;
    b_zero_r <= (a_max_r == '0);
    c_m_r    <= m_nxt;
    c_neg_r  <= b_vec_r.neg;
    c_side_r <= b_side_r;
    c_zero_r <= b_zero_r;
    for (int i = 0; i < 3; i++) begin
      d_sq_r[i] <= {{NM_W{1'b0}}, c_m_r[i]} * {{NM_W{1'b0}}, c_m_r[i]};
    end
    d_m_r    <= c_m_r;
    d_neg_r  <= c_neg_r;
    d_side_r <= c_side_r;
    d_zero_r <= c_zero_r;
  end

  // Square root pipeline, one result bit per stage. Entry 0 holds the sum.
  logic                   rt_valid_r [0:RS];
  logic [SUM_W-1:0]       rt_x_r     [0:RS];
  logic [SUM_W-1:0]       rt_res_r   [0:RS];
  logic [2:0][NM_W-1:0]   rt_m_r     [0:RS];
  logic [2:0]             rt_neg_r   [0:RS];
  cob_pkg::side_t         rt_side_r  [0:RS];
  logic                   rt_zero_r  [0:RS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_valid_r[0] <= 1'b0;
    end else begin
      rt_valid_r[0] <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    rt_x_r[0]    <= SUM_W'(d_sq_r[0]) + SUM_W'(d_sq_r[1]) + SUM_W'(d_sq_r[2]);
    rt_res_r[0]  <= '0;
    rt_m_r[0]    <= d_m_r;
    rt_neg_r[0]  <= d_neg_r;
    rt_side_r[0] <= d_side_r;
    rt_zero_r[0] <= d_zero_r;
  end

  for (genvar k = 0; k < RS; k++) begin : g_root
    localparam logic [SUM_W-1:0] RBIT = SUM_W'(1) << (2 * (RS - 1 - k));
    logic [SUM_W-1:0] trial;
    assign trial = rt_res_r[k] + RBIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_valid_r[k+1] <= 1'b0;
      end else begin
        rt_valid_r[k+1] <= rt_valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rt_x_r[k] >= trial) begin
        rt_x_r[k+1]   <= rt_x_r[k] - trial;
        rt_res_r[k+1] <= (rt_res_r[k] >> 1) + RBIT;
      end else begin
        rt_x_r[k+1]   <= rt_x_r[k];
        rt_res_r[k+1] <= rt_res_r[k] >> 1;
      end
      rt_m_r[k+1]    <= rt_m_r[k];
      rt_neg_r[k+1]  <= rt_neg_r[k];
      rt_side_r[k+1] <= rt_side_r[k];
      rt_zero_r[k+1] <= rt_zero_r[k];
    end
  end

  // Restoring division, one quotient bit per stage, three lanes side by side.
  logic                    dv_valid_r [0:DS];
  logic [2:0][NUM_W-1:0]   dv_rem_r   [0:DS];
  logic [2:0][QUO_W-1:0]   dv_q_r     [0:DS];
  logic [ROOT_W-1:0]       dv_n_r     [0:DS];
  logic [2:0]              dv_neg_r   [0:DS];
  cob_pkg::side_t          dv_side_r  [0:DS];
  logic                    dv_zero_r  [0:DS];
  logic [ROOT_W-1:0]       root;

  assign root = rt_res_r[RS][ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else begin
      dv_valid_r[0] <= rt_valid_r[RS];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= NUM_W'({rt_m_r[RS][i], {NM_W{1'b0}}}) + NUM_W'(root >> 1);
    end
    dv_q_r[0]    <= '0;
    dv_n_r[0]    <= root;
    dv_neg_r[0]  <= rt_neg_r[RS];
    dv_side_r[0] <= rt_side_r[RS];
    dv_zero_r[0] <= rt_zero_r[RS];
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    localparam int unsigned SH = DS - 1 - j;
    logic [NUM_W-1:0]        dn;
    logic [2:0][NUM_W-1:0]   rem_nxt;
    logic [2:0][QUO_W-1:0]   q_nxt;

    assign dn = NUM_W'(dv_n_r[j]) << SH;

    always_comb begin
      rem_nxt = dv_rem_r[j];
      q_nxt   = dv_q_r[j];
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_r[j][i] >= dn) begin
          rem_nxt[i]   = dv_rem_r[j][i] - dn;
          q_nxt[i][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[j+1] <= 1'b0;
      end else begin
        dv_valid_r[j+1] <= dv_valid_r[j];
      end
    end

    always_ff @(posedge clk) begin
      dv_rem_r[j+1]  <= rem_nxt;
      dv_q_r[j+1]    <= q_nxt;
      dv_n_r[j+1]    <= dv_n_r[j];
      dv_neg_r[j+1]  <= dv_neg_r[j];
      dv_side_r[j+1] <= dv_side_r[j];
      dv_zero_r[j+1] <= dv_zero_r[j];
    end
  end

  // Sign restore and output register.
  logic             o_valid_r;
  cob_pkg::vec3_t   o_vec_r;
  logic             o_zero_r;
  cob_pkg::side_t   o_side_r;
  cob_pkg::vec3_t   o_vec_nxt;

  always_comb begin
    logic [FIX_W-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = FIX_W'(dv_q_r[DS][i]);
      if (dv_zero_r[DS]) begin
        o_vec_nxt[i] = '0;
      end else if (dv_neg_r[DS][i]) begin
        o_vec_nxt[i] = -q;
      end else begin
        o_vec_nxt[i] = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= dv_valid_r[DS];
    end
  end

  always_ff @(posedge clk) begin
    o_vec_r  <= o_vec_nxt;
    o_zero_r <= dv_zero_r[DS];
    o_side_r <= dv_side_r[DS];
  end

  assign out_valid = o_valid_r;
  assign out_vec   = o_vec_r;
  assign out_zero  = o_zero_r;
  assign out_side  = o_side_r;

endmodule

### sv/camera_orthonormal_basis_top.sv
// Top level of the look-at camera basis block: input register, two normalizers, two cross products.
// Throughput: one item per cycle; busy stays low, so start may be high in every cycle.
// The depth is set by the two normalizers, each a 32-step square root and a 31-step divider.
// Reset (rst_n low, synchronous) clears every valid bit and loads up = (0, 1, 0).
// The receiver cannot stall: each result is on out_data for exactly the cycle of out_valid.
module camera_orthonormal_basis_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  cob_pkg::in_t                in_data,
  output logic                        out_valid,
  output cob_pkg::out_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned FIX_W  = cob_pkg::FIX_W;
  localparam int unsigned MAG_W  = cob_pkg::MAG_W;
  localparam int unsigned PROD_W = cob_pkg::PROD_W;

  // The datapath never backs up, so an item is taken in every cycle that start is high.
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Up vector registers. The user must change them only while no item is in
  // flight; the block does not enforce this, and the pipeline reads them directly.
  cob_pkg::vec3_t up_r;
  logic [1:0]     reg_idx;

  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r[0] <= cob_pkg::UP_X_RST;
      up_r[1] <= cob_pkg::UP_Y_RST;
      up_r[2] <= cob_pkg::UP_Z_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        cob_pkg::REG_UP_X: up_r[0] <= pwdata;
        cob_pkg::REG_UP_Y: up_r[1] <= pwdata;
        cob_pkg::REG_UP_Z: up_r[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cob_pkg::REG_UP_X: prdata = up_r[0];
      cob_pkg::REG_UP_Y: prdata = up_r[1];
      cob_pkg::REG_UP_Z: prdata = up_r[2];
      default:           prdata = '0;
    endcase
  end

  // Input register.
  logic          in_valid_r;
  cob_pkg::in_t  in_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_data_r <= in_data;
    end
  end

  // The direction pos - tgt, as sign and magnitude, and the view class. When
  // position and target share X and Z but not Y, the camera looks straight
  // down or straight up and fixed axes replace the computed basis.
  logic signed [FIX_W:0] diff [3];
  cob_pkg::nvec_t        n1_in_vec;
  cob_pkg::side_t        n1_in_side;

  always_comb begin
    logic [FIX_W:0] m;
    diff[0] = $signed({in_data_r.pos_x[FIX_W-1], in_data_r.pos_x})
            - $signed({in_data_r.tgt_x[FIX_W-1], in_data_r.tgt_x});
    diff[1] = $signed({in_data_r.pos_y[FIX_W-1], in_data_r.pos_y})
            - $signed({in_data_r.tgt_y[FIX_W-1], in_data_r.tgt_y});
    diff[2] = $signed({in_data_r.pos_z[FIX_W-1], in_data_r.pos_z})
            - $signed({in_data_r.tgt_z[FIX_W-1], in_data_r.tgt_z});
    for (int i = 0; i < 3; i++) begin
      n1_in_vec.neg[i] = diff[i][FIX_W];
      m = diff[i][FIX_W] ? -diff[i] : diff[i];
      n1_in_vec.mag[i] = MAG_W'(m);
    end
    n1_in_side = '0;
    if (diff[0] == '0 && diff[2] == '0 && diff[1] != '0) begin
      n1_in_side.kind = diff[1][FIX_W] ? cob_pkg::KIND_UP : cob_pkg::KIND_DOWN;
    end else begin
      n1_in_side.kind = cob_pkg::KIND_NORMAL;
    end
  end

  // First normalizer: w.
  logic            n1_valid;
  cob_pkg::vec3_t  n1_vec;
  logic            n1_zero;
  cob_pkg::side_t  n1_side;

  cob_norm u_norm_w (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid_r),
    .in_vec    (n1_in_vec),
    .in_side   (n1_in_side),
    .out_valid (n1_valid),
    .out_vec   (n1_vec),
    .out_zero  (n1_zero),
    .out_side  (n1_side)
  );

  // w travels with the item from here on; a zero direction marks it degenerate.
  cob_pkg::side_t  x1_side;

  always_comb begin
    x1_side   = n1_side;
    x1_side.w = n1_vec;
    if (n1_side.kind == cob_pkg::KIND_NORMAL && n1_zero) begin
      x1_side.kind = cob_pkg::KIND_DEGEN;
    end
  end

  // up x w, at full precision.
  logic             x1_valid;
  cob_pkg::wide3_t  x1_c;
  cob_pkg::side_t   x1_out_side;

  cob_cross u_cross_up_w (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (n1_valid),
    .in_a      (up_r),
    .in_b      (n1_vec),
    .in_side   (x1_side),
    .out_valid (x1_valid),
    .out_c     (x1_c),
    .out_side  (x1_out_side)
  );

  cob_pkg::nvec_t n2_in_vec;

  always_comb begin
    logic [PROD_W-1:0] m;
    for (int i = 0; i < 3; i++) begin
      n2_in_vec.neg[i] = x1_c[i][PROD_W-1];
      m = x1_c[i][PROD_W-1] ? -x1_c[i] : x1_c[i];
      n2_in_vec.mag[i] = m[MAG_W-1:0];
    end
  end

  // Second normalizer: u.
  logic            n2_valid;
  cob_pkg::vec3_t  n2_vec;
  logic            n2_zero;
  cob_pkg::side_t  n2_side;

  cob_norm u_norm_u (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (x1_valid),
    .in_vec    (n2_in_vec),
    .in_side   (x1_out_side),
    .out_valid (n2_valid),
    .out_vec   (n2_vec),
    .out_zero  (n2_zero),
    .out_side  (n2_side)
  );

  // An up vector that is zero or parallel to w gives a zero cross product.
  cob_pkg::side_t  x2_side;

  always_comb begin
    x2_side   = n2_side;
    x2_side.u = n2_vec;
    if (n2_side.kind == cob_pkg::KIND_NORMAL && n2_zero) begin
      x2_side.kind = cob_pkg::KIND_DEGEN;
    end
  end

  // w x u, rounded to Q1.30 in the output stage.
  logic             x2_valid;
  cob_pkg::wide3_t  x2_c;
  cob_pkg::side_t   x2_out_side;

  cob_cross u_cross_w_u (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (n2_valid),
    .in_a      (x2_side.w),
    .in_b      (n2_vec),
    .in_side   (x2_side),
    .out_valid (x2_valid),
    .out_c     (x2_c),
    .out_side  (x2_out_side)
  );

  // Output stage: round v half away from zero, clamp to one, then pick the
  // basis by view class.
  logic           out_valid_r;
  cob_pkg::out_t  out_data_r;
  cob_pkg::out_t  out_nxt;
  cob_pkg::vec3_t v_rnd;

  always_comb begin
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] r;
    for (int i = 0; i < 3; i++) begin
      m = x2_c[i][PROD_W-1] ? -x2_c[i] : x2_c[i];
      r = (m + cob_pkg::RND_HALF) >> cob_pkg::Q30_SHIFT;
      if (r > PROD_W'(cob_pkg::ONE_Q30)) begin
        r = PROD_W'(cob_pkg::ONE_Q30);
      end
      v_rnd[i] = x2_c[i][PROD_W-1] ? -r[FIX_W-1:0] : r[FIX_W-1:0];
    end
  end

  always_comb begin
    out_nxt = '0;
    case (x2_out_side.kind)
      cob_pkg::KIND_NORMAL: begin
        out_nxt.u_x = x2_out_side.u[0];
        out_nxt.u_y = x2_out_side.u[1];
        out_nxt.u_z = x2_out_side.u[2];
        out_nxt.v_x = v_rnd[0];
        out_nxt.v_y = v_rnd[1];
        out_nxt.v_z = v_rnd[2];
        out_nxt.w_x = x2_out_side.w[0];
        out_nxt.w_y = x2_out_side.w[1];
        out_nxt.w_z = x2_out_side.w[2];
      end
      cob_pkg::KIND_DOWN: begin
        out_nxt.u_z = cob_pkg::ONE_Q30;
        out_nxt.v_x = cob_pkg::ONE_Q30;
        out_nxt.w_y = cob_pkg::ONE_Q30;
      end
      cob_pkg::KIND_UP: begin
        out_nxt.u_x = cob_pkg::ONE_Q30;
        out_nxt.v_z = cob_pkg::ONE_Q30;
        out_nxt.w_y = -cob_pkg::ONE_Q30;
      end
      default: begin
        out_nxt.degenerate = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= x2_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/cob_checker.sv
// Port-level checks of the camera basis block and their binding to the top level.
module cob_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input cob_pkg::out_t  out_data
);

  // A result appears only for an item accepted the pipeline depth earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, cob_pkg::LATENCY))
    else $error("result without a matching accepted item");

  // Reset flushes the pipeline.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // A degenerate result carries an all-zero basis.
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.u_x == 0 && out_data.u_y == 0 && out_data.u_z == 0 &&
      out_data.v_x == 0 && out_data.v_y == 0 && out_data.v_z == 0 &&
      out_data.w_x == 0 && out_data.w_y == 0 && out_data.w_z == 0)
    else $error("degenerate result with nonzero basis");

  // Every w component stays within one in magnitude.
  a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_data.w_x <= cob_pkg::ONE_Q30 && out_data.w_x >= -cob_pkg::ONE_Q30 &&
      out_data.w_y <= cob_pkg::ONE_Q30 && out_data.w_y >= -cob_pkg::ONE_Q30 &&
      out_data.w_z <= cob_pkg::ONE_Q30 && out_data.w_z >= -cob_pkg::ONE_Q30)
    else $error("w component out of range");

endmodule

bind camera_orthonormal_basis_top cob_checker u_cob_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
